/* hdl/lnf_pkg.sv */
`default_nettype none

package lnf_pkg;

    localparam int MAX_WIDTH  = 16;
    localparam int NUM_DIGITS = 5;
    localparam int DIG_IDX_W  = $clog2(NUM_DIGITS);
    localparam int CNT_W      = $clog2(MAX_WIDTH + 1);
    localparam int MAG_W      = 17;
    localparam int PC_W       = 4;

    // floor(m / 10) == (m * DIV10_MUL) >> DIV10_SHIFT for every m below 2^18
    localparam logic [MAG_W-1:0] DIV10_MUL   = 17'd52429;
    localparam int               DIV10_SHIFT = 19;

    localparam logic [7:0] CMD_LINE0 = 8'h80;
    localparam logic [7:0] CMD_LINE1 = 8'hC0;
    localparam logic [3:0] COL_MAX   = 4'd15;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOT    = 8'h2E;

    localparam logic CMD_INT   = 1'b0;
    localparam logic CMD_FIXED = 1'b1;

    typedef struct packed {
        logic               command;
        logic               row;
        logic [4:0]         col;
        logic signed [15:0] value;
        logic [4:0]         width;
    } lnf_req_t;

    typedef struct packed {
        logic       is_data;
        logic [7:0] bus_byte;
        logic       last;
    } lnf_wr_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_WAIT,
        OP_DIV,
        OP_SETUP,
        OP_CURSOR,
        OP_SPACE,
        OP_SIGN,
        OP_DIGIT,
        OP_DOT
    } lnf_op_t;

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_REQ,
        C_DIV_MORE,
        C_CNT_ZERO,
        C_CNT_NZ,
        C_CNT_GT1,
        C_FIXED
    } lnf_cond_t;

    typedef struct packed {
        lnf_op_t         op;
        lnf_cond_t       cond;
        logic [PC_W-1:0] target;
    } lnf_ctrl_t;

    typedef struct packed {
        logic stall;
        logic req_valid;
        logic div_more;
        logic cnt_zero;
        logic cnt_gt1;
        logic fixed;
    } lnf_stat_t;

    localparam logic [PC_W-1:0] PC_WAIT      = 4'd0;
    localparam logic [PC_W-1:0] PC_DIV       = 4'd1;
    localparam logic [PC_W-1:0] PC_PAD_LOOP  = 4'd5;
    localparam logic [PC_W-1:0] PC_SIGN      = 4'd6;
    localparam logic [PC_W-1:0] PC_INT_DIG   = 4'd8;
    localparam logic [PC_W-1:0] PC_FIX_DIG   = 4'd10;

endpackage

`default_nettype wire

/* hdl/lcd_number_formatter.sv */
// Number formatter for a character display.
// Request channel (req_valid/req_ready/req_data): one number to show, with
// mode, row, column and field width. req_ready is high only while the
// sequencer waits for a new request; one request is handled at a time.
// Write channel (wr_valid/wr_ready/wr_data): one display bus write per
// handshake, a cursor command first, then characters; last marks the end.
// Sequence: after acceptance, five divide-by-ten steps (one multiplier pass
// each), one setup step and the cursor step run; the cursor write goes to
// the result register. Then one write per cycle while wr_ready stays high,
// with one idle step after the cursor, a sign step that is idle for positive
// values, one idle step before the digits and, in integer mode, one at the
// end.
// A result register sits on the write side: the sequencer stalls only when
// it holds an untaken write and wr_ready is low; nothing is dropped.
// Reset clears the step counter and the output valid flag; the block then
// waits for a request.
`default_nettype none

module lcd_number_formatter
    import lnf_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire lnf_req_t req_data,
    output logic          wr_valid,
    input  wire logic     wr_ready,
    output lnf_wr_t       wr_data
);

    logic [PC_W-1:0] pc;
    lnf_ctrl_t       ctrl;
    lnf_stat_t       stat;

    lnf_ucode_rom u_rom (
        .pc   (pc),
        .ctrl (ctrl)
    );

    lnf_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .stat  (stat),
        .pc    (pc)
    );

    lnf_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .stat      (stat),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .wr_valid  (wr_valid),
        .wr_ready  (wr_ready),
        .wr_data   (wr_data)
    );

endmodule

`default_nettype wire

/* hdl/lnf_ucode_rom.sv */
`default_nettype none

module lnf_ucode_rom
    import lnf_pkg::*;
(
    input  wire logic [PC_W-1:0] pc,
    output lnf_ctrl_t            ctrl
);

    always_comb
    begin
        unique case (pc)
            4'd0:    ctrl = '{OP_WAIT,   C_NO_REQ,   PC_WAIT};
            4'd1:    ctrl = '{OP_DIV,    C_DIV_MORE, PC_DIV};
            4'd2:    ctrl = '{OP_SETUP,  C_NEXT,     PC_WAIT};
            4'd3:    ctrl = '{OP_CURSOR, C_NEXT,     PC_WAIT};
            4'd4:    ctrl = '{OP_NOP,    C_CNT_ZERO, PC_SIGN};
            4'd5:    ctrl = '{OP_SPACE,  C_CNT_GT1,  PC_PAD_LOOP};
            4'd6:    ctrl = '{OP_SIGN,   C_NEXT,     PC_WAIT};
            4'd7:    ctrl = '{OP_NOP,    C_FIXED,    PC_FIX_DIG};
            4'd8:    ctrl = '{OP_DIGIT,  C_CNT_NZ,   PC_INT_DIG};
            4'd9:    ctrl = '{OP_NOP,    C_ALWAYS,   PC_WAIT};
            4'd10:   ctrl = '{OP_DIGIT,  C_CNT_GT1,  PC_FIX_DIG};
            4'd11:   ctrl = '{OP_DOT,    C_NEXT,     PC_WAIT};
            4'd12:   ctrl = '{OP_DIGIT,  C_ALWAYS,   PC_WAIT};
            default: ctrl = '{OP_NOP,    C_ALWAYS,   PC_WAIT};
        endcase
    end

endmodule

`default_nettype wire

/* hdl/lnf_sequencer.sv */
`default_nettype none

module lnf_sequencer
    import lnf_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire lnf_ctrl_t       ctrl,
    input  wire lnf_stat_t       stat,
    output logic [PC_W-1:0]      pc
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            take;

    always_comb
    begin
        unique case (ctrl.cond)
            C_NEXT:     take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_NO_REQ:   take = !stat.req_valid;
            C_DIV_MORE: take = stat.div_more;
            C_CNT_ZERO: take = stat.cnt_zero;
            C_CNT_NZ:   take = !stat.cnt_zero;
            C_CNT_GT1:  take = stat.cnt_gt1;
            C_FIXED:    take = stat.fixed;
            default:    take = 1'b0;
        endcase

        priority if (stat.stall)
            pc_next = pc_reg;
        else if (take)
            pc_next = ctrl.target;
        else
            pc_next = pc_reg + PC_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= PC_WAIT;
        else
            pc_reg <= pc_next;
    end

    assign pc = pc_reg;

endmodule

`default_nettype wire

/* hdl/lnf_datapath.sv */
`default_nettype none

module lnf_datapath
    import lnf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire lnf_ctrl_t ctrl,
    output lnf_stat_t      stat,
    input  wire logic      req_valid,
    output logic           req_ready,
    input  wire lnf_req_t  req_data,
    output logic           wr_valid,
    input  wire logic      wr_ready,
    output lnf_wr_t        wr_data
);

    logic             cmd_reg, cmd_next;
    logic             row_reg, row_next;
    logic [3:0]       col_reg, col_next;
    logic [4:0]       width_reg, width_next;
    logic             neg_reg, neg_next;
    logic [MAG_W-1:0] mag_reg, mag_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [2:0]       ndig_reg, ndig_next;
    logic [3:0]       digit_reg [NUM_DIGITS];
    logic [3:0]       digit_next [NUM_DIGITS];
    logic             out_valid_reg, out_valid_next;
    lnf_wr_t          out_reg, out_next;

    logic [2*MAG_W-1:0] prod;
    logic [MAG_W-1:0]   quo;
    logic [MAG_W-1:0]   rem_full;
    logic [DIG_IDX_W-1:0] idx;
    logic [CNT_W-1:0]   w_clamp;
    logic [CNT_W-1:0]   len;
    logic [CNT_W-1:0]   pad;
    logic               emit;
    logic               can_load;
    logic               stall;
    lnf_wr_t            wr_new;

    assign idx      = cnt_reg[DIG_IDX_W-1:0];
    assign prod     = mag_reg * DIV10_MUL;
    assign quo      = MAG_W'(prod >> DIV10_SHIFT);
    assign rem_full = mag_reg - ({quo[MAG_W-4:0], 3'b000} + {quo[MAG_W-2:0], 1'b0});

    always_comb
    begin
        if (int'(width_reg) > MAX_WIDTH)
            w_clamp = CNT_W'(MAX_WIDTH);
        else
            w_clamp = CNT_W'(width_reg);
        len = CNT_W'(ndig_reg) + CNT_W'(neg_reg);
        pad = (w_clamp > len) ? (w_clamp - len) : '0;
    end

    always_comb
    begin
        wr_new = '{1'b1, CH_SPACE, 1'b0};
        emit   = 1'b0;
        unique case (ctrl.op)
            OP_CURSOR:
            begin
                emit   = 1'b1;
                wr_new = '{1'b0, (row_reg ? CMD_LINE1 : CMD_LINE0) | {4'b0000, col_reg}, 1'b0};
            end
            OP_SPACE:
            begin
                emit = 1'b1;
            end
            OP_SIGN:
            begin
                emit   = neg_reg;
                wr_new = '{1'b1, CH_MINUS, 1'b0};
            end
            OP_DIGIT:
            begin
                emit   = 1'b1;
                wr_new = '{1'b1, CH_ZERO | {4'b0000, digit_reg[idx]}, (cnt_reg == '0)};
            end
            OP_DOT:
            begin
                emit   = 1'b1;
                wr_new = '{1'b1, CH_DOT, 1'b0};
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    assign can_load  = !out_valid_reg || wr_ready;
    assign stall     = emit && !can_load;
    assign req_ready = (ctrl.op == OP_WAIT);

    always_comb
    begin
        cmd_next       = cmd_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        width_next     = width_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        cnt_next       = cnt_reg;
        ndig_next      = ndig_reg;
        digit_next     = digit_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !wr_ready;

        if (emit && can_load)
        begin
            out_next       = wr_new;
            out_valid_next = 1'b1;
        end

        if (!stall)
        begin
            unique case (ctrl.op)
                OP_WAIT:
                begin
                    if (req_valid)
                    begin
                        cmd_next   = req_data.command;
                        row_next   = req_data.row;
                        col_next   = (req_data.col > {1'b0, COL_MAX}) ? COL_MAX
                                                                      : req_data.col[3:0];
                        width_next = req_data.width;
                        neg_next   = req_data.value[15];
                        mag_next   = req_data.value[15]
                                   ? (MAG_W'(17'h10000) - {1'b0, req_data.value})
                                   : {1'b0, req_data.value};
                        cnt_next   = '0;
                        ndig_next  = 3'd1;
                    end
                end
                OP_DIV:
                begin
                    mag_next        = quo;
                    digit_next[idx] = rem_full[3:0];
                    cnt_next        = cnt_reg + CNT_W'(1);
                    if (quo != '0)
                        ndig_next = 3'(idx) + 3'd2;
                end
                OP_SETUP:
                begin
                    if (cmd_reg == CMD_FIXED)
                    begin
                        cnt_next = '0;
                        if (ndig_reg < 3'd2)
                            ndig_next = 3'd2;
                    end
                    else
                        cnt_next = pad;
                end
                OP_SPACE, OP_DIGIT:
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
                OP_SIGN:
                begin
                    cnt_next = CNT_W'(ndig_reg - 3'd1);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            ndig_reg      <= 3'd1;
            cnt_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            ndig_reg      <= ndig_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        row_reg   <= row_next;
        col_reg   <= col_next;
        width_reg <= width_next;
        neg_reg   <= neg_next;
        mag_reg   <= mag_next;
        out_reg   <= out_next;
        for (int i = 0; i < NUM_DIGITS; i++)
            digit_reg[i] <= digit_next[i];
    end

    assign wr_valid = out_valid_reg;
    assign wr_data  = out_reg;

    assign stat.stall     = stall;
    assign stat.req_valid = req_valid;
    assign stat.div_more  = (cnt_reg != CNT_W'(NUM_DIGITS - 1));
    assign stat.cnt_zero  = (cnt_reg == '0);
    assign stat.cnt_gt1   = (cnt_reg > CNT_W'(1));
    assign stat.fixed     = (cmd_reg == CMD_FIXED);

    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken while previous one still converting");

    a_last_is_char: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_valid && wr_data.last) |-> wr_data.is_data)
        else $error("final write of a request is a command byte");

    a_cursor_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_valid && !wr_data.is_data) |-> (wr_data.bus_byte[7] && !wr_data.last))
        else $error("malformed cursor command");

    a_ndig_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ndig_reg >= 3'd1) && (ndig_reg <= 3'(NUM_DIGITS)))
        else $error("digit count out of range");

endmodule

`default_nettype wire
